// ===== sv/bpstego_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego package
// Shared types, register indexes and sizing constants of the embed/extract block.
// ----------------------------------------------------------------------------
package bpstego_pkg;

    localparam int BLOCK_SIDE = 8;
    localparam int MAX_DIM    = 4096;
    localparam int MSG_DEPTH  = 48;
    localparam int NUM_LANES  = 3;

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int SIZE_W     = DIM_W + 1;
    localparam int CMP_W      = DIM_W + 2;
    localparam int MSG_IDX_W  = $clog2(MSG_DEPTH);
    localparam int SLOT_W     = MSG_IDX_W + 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_R  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_C  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MSG_LEN  = 3'd6;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [1:0]        plane;
        logic [DIM_W-1:0]  block_row;
        logic [DIM_W-1:0]  block_col;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [5:0]        message_length;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [5:0] msg_index;
        logic [7:0] msg_byte;
        logic       start_of_frame;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       byte_valid;
        logic [7:0] extracted_byte;
        logic       out_of_bounds;
    } t_out;

    typedef struct packed {
        logic [NUM_LANES-1:0][7:0] chan;
        logic [NUM_LANES-1:0]      en;
        logic [NUM_LANES-1:0][1:0] pos;
        logic [NUM_LANES-1:0]      sel_b;
        logic [7:0]                rd_a;
        logic [7:0]                rd_b;
        logic                      sof;
        logic                      oob;
    } t_s1;

endpackage

// ===== sv/bpstego_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego input channel
// Valid/ready channel carrying message byte writes and pixels.
// ----------------------------------------------------------------------------
interface bpstego_in_if;
    import bpstego_pkg::*;

    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ===== sv/bpstego_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego output channel
// Valid/ready channel carrying one processed pixel per transfer.
// ----------------------------------------------------------------------------
interface bpstego_out_if;
    import bpstego_pkg::*;

    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ===== sv/bpstego_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego lane
// Embeds a message bit pair into one colour channel, or picks the pair out.
// ----------------------------------------------------------------------------
module bpstego_lane (
    input  logic [7:0] i_chan,
    input  logic       i_en,
    input  logic [1:0] i_pos,
    input  logic [7:0] i_byte,
    input  logic [1:0] i_plane,
    input  logic       i_mode,
    output logic [7:0] o_chan,
    output logic [1:0] o_pair
);
    import bpstego_pkg::*;

    logic [2:0] shift;
    logic [2:0] msg_shift;
    logic [1:0] msg_pair;
    logic [7:0] mask;
    logic [7:0] embedded;

    assign shift     = 3'd6 - {i_plane, 1'b0};
    assign msg_shift = 3'd6 - {i_pos, 1'b0};
    assign msg_pair  = 2'(i_byte >> msg_shift);
    assign mask      = 8'd3 << shift;
    assign embedded  = (i_chan & ~mask) | (8'(msg_pair) << shift);
    assign o_chan    = (i_en && i_mode == MODE_EMBED) ? embedded : i_chan;
    assign o_pair    = 2'(i_chan >> shift);
endmodule

// ===== sv/bpstego_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego front end
// Raster and slot counters, message store and per-lane slot enables.
// ----------------------------------------------------------------------------
module bpstego_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpstego_pkg::t_cfg i_cfg,
    input  logic              i_in_valid,
    input  bpstego_pkg::t_in  i_in_data,
    input  logic              i_take,
    output logic              o_in_ready,
    output logic              o_s1_valid,
    output bpstego_pkg::t_s1  o_s1
);
    import bpstego_pkg::*;

    logic [7:0]        r_store [MSG_DEPTH];
    logic [DIM_W-1:0]  r_row;
    logic [DIM_W-1:0]  n_row;
    logic [DIM_W-1:0]  r_col;
    logic [DIM_W-1:0]  n_col;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_s1_valid;
    t_s1               r_s1;

    logic                  in_acc;
    logic                  pix_acc;
    logic                  byte_acc;
    logic [DIM_W-1:0]      row_cur;
    logic [DIM_W-1:0]      col_cur;
    logic [SLOT_W-1:0]     slot_cur;
    logic                  oob;
    logic                  in_blk;
    logic [5:0]            len_eff;
    logic [SLOT_W-1:0]     limit;
    logic [SIZE_W-1:0]     width_eff;
    logic [NUM_LANES-1:0]  en;
    logic [NUM_LANES-1:0]  sel_b;
    logic [NUM_LANES-1:0][1:0]    pos;
    logic [NUM_LANES-1:0][SLOT_W:0] slot_k;
    logic [SLOT_W-1:0]     adv;

    assign o_in_ready = !r_s1_valid || i_take;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pix_acc    = in_acc && i_in_data.kind == KIND_PIXEL;
    assign byte_acc   = in_acc && i_in_data.kind == KIND_BYTE;

    assign row_cur  = i_in_data.start_of_frame ? '0 : r_row;
    assign col_cur  = i_in_data.start_of_frame ? '0 : r_col;
    assign slot_cur = i_in_data.start_of_frame ? '0 : r_slot;

    assign oob = (CMP_W'(i_cfg.block_row) + CMP_W'(BLOCK_SIDE) > CMP_W'(i_cfg.image_height))
              || (CMP_W'(i_cfg.block_col) + CMP_W'(BLOCK_SIDE) > CMP_W'(i_cfg.image_width));

    assign in_blk = (row_cur >= i_cfg.block_row)
                 && (CMP_W'(row_cur) < CMP_W'(i_cfg.block_row) + CMP_W'(BLOCK_SIDE))
                 && (col_cur >= i_cfg.block_col)
                 && (CMP_W'(col_cur) < CMP_W'(i_cfg.block_col) + CMP_W'(BLOCK_SIDE));

    assign len_eff = (i_cfg.message_length > 6'(MSG_DEPTH)) ? 6'(MSG_DEPTH)
                                                            : i_cfg.message_length;
    assign limit   = SLOT_W'({len_eff, 2'b00});

    always_comb begin
        adv = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            slot_k[k] = (SLOT_W + 1)'(slot_cur) + (SLOT_W + 1)'(k);
            en[k]     = !oob && in_blk && (slot_k[k] < (SLOT_W + 1)'(limit));
            pos[k]    = slot_k[k][1:0];
            sel_b[k]  = slot_k[k][SLOT_W-1:2] != slot_cur[SLOT_W-1:2];
            adv       = adv + SLOT_W'(en[k]);
        end
    end

    assign width_eff = (i_cfg.image_width > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM)
                                                              : i_cfg.image_width;

    always_comb begin
        n_slot = slot_cur + adv;
        if (SIZE_W'(col_cur) + SIZE_W'(1) >= width_eff) begin
            n_col = '0;
            n_row = (row_cur == DIM_W'(MAX_DIM - 1)) ? row_cur : row_cur + DIM_W'(1);
        end else begin
            n_col = col_cur + DIM_W'(1);
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_slot     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (pix_acc) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_slot     <= n_slot;
                r_s1_valid <= 1'b1;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_acc && i_in_data.msg_index < 6'(MSG_DEPTH)) begin
            r_store[i_in_data.msg_index[MSG_IDX_W-1:0]] <= i_in_data.msg_byte;
        end
        if (pix_acc) begin
            r_s1.chan  <= {i_in_data.red, i_in_data.green, i_in_data.blue};
            r_s1.en    <= en;
            r_s1.pos   <= pos;
            r_s1.sel_b <= sel_b;
            r_s1.sof   <= i_in_data.start_of_frame;
            r_s1.oob   <= oob;
            if (en[0]) begin
                r_s1.rd_a <= r_store[slot_cur[SLOT_W-1:2]];
            end
            if (|en[NUM_LANES-1:1]) begin
                r_s1.rd_b <= r_store[slot_k[NUM_LANES-1][SLOT_W-1:2]];
            end
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
endmodule

// ===== sv/bpstego_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego merge stage
// Runs the three channel lanes, assembles extracted bytes and holds the result.
// ----------------------------------------------------------------------------
module bpstego_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpstego_pkg::t_cfg i_cfg,
    input  logic              i_s1_valid,
    input  bpstego_pkg::t_s1  i_s1,
    input  logic              i_out_ready,
    output logic              o_take,
    output logic              o_out_valid,
    output bpstego_pkg::t_out o_out
);
    import bpstego_pkg::*;

    logic [7:0] r_gather;
    logic [7:0] n_gather;
    logic       r_out_valid;
    t_out       r_out;

    logic [NUM_LANES-1:0][7:0] chan_out;
    logic [NUM_LANES-1:0][1:0] pair;
    logic                      done;
    logic [7:0]                word;

    assign o_take = i_s1_valid && (!r_out_valid || i_out_ready);

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        bpstego_lane u_lane (
            .i_chan  (i_s1.chan[k]),
            .i_en    (i_s1.en[k]),
            .i_pos   (i_s1.pos[k]),
            .i_byte  (i_s1.sel_b[k] ? i_s1.rd_b : i_s1.rd_a),
            .i_plane (i_cfg.plane),
            .i_mode  (i_cfg.mode),
            .o_chan  (chan_out[k]),
            .o_pair  (pair[k])
        );
    end

    always_comb begin
        n_gather = i_s1.sof ? 8'd0 : r_gather;
        done     = 1'b0;
        word     = 8'd0;
        if (i_cfg.mode == MODE_EXTRACT) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (i_s1.en[k]) begin
                    n_gather = n_gather | (8'(pair[k]) << (3'd6 - {i_s1.pos[k], 1'b0}));
                    if (i_s1.pos[k] == 2'd3) begin
                        done     = 1'b1;
                        word     = n_gather;
                        n_gather = 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_gather    <= n_gather;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.out_blue       <= chan_out[0];
            r_out.out_green      <= chan_out[1];
            r_out.out_red        <= chan_out[2];
            r_out.byte_valid     <= done;
            r_out.extracted_byte <= word;
            r_out.out_of_bounds  <= i_s1.oob;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// ===== sv/bitplane_block_stego_embed_extract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane block stego embed/extract
// Embeds message bit pairs into, or extracts them from, an 8x8 carrier block.
// ----------------------------------------------------------------------------
// A pixel's result is registered in the front stage and then in the merge stage.
// Throughput: one item per cycle while the result channel is not stalled; byte writes are absorbed and give no result.
// The two pipeline stages are the message store read and the lane/merge stage.
// Reset clears the counters, the gather word, the pipeline and loads the
// register defaults; the message store holds garbage until it is written.
module bitplane_block_stego_embed_extract (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bpstego_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bpstego_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bpstego_in_if.sink                           i_in,
    bpstego_out_if.source                        o_out
);
    import bpstego_pkg::*;

    t_cfg r_cfg;
    logic s1_valid;
    t_s1  s1;
    logic take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_EMBED;
            r_cfg.plane          <= 2'd0;
            r_cfg.block_row      <= '0;
            r_cfg.block_col      <= '0;
            r_cfg.image_width    <= SIZE_W'(640);
            r_cfg.image_height   <= SIZE_W'(480);
            r_cfg.message_length <= 6'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:    r_cfg.mode           <= i_cfg_wdata[0];
                REG_PLANE:   r_cfg.plane          <= i_cfg_wdata[1:0];
                REG_BLOCK_R: r_cfg.block_row      <= i_cfg_wdata[DIM_W-1:0];
                REG_BLOCK_C: r_cfg.block_col      <= i_cfg_wdata[DIM_W-1:0];
                REG_WIDTH:   r_cfg.image_width    <= i_cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT:  r_cfg.image_height   <= i_cfg_wdata[SIZE_W-1:0];
                REG_MSG_LEN: r_cfg.message_length <= i_cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    bpstego_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in.valid),
        .i_in_data  (i_in.data),
        .i_take     (take),
        .o_in_ready (i_in.ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    bpstego_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_out_ready (o_out.ready),
        .o_take      (take),
        .o_out_valid (o_out.valid),
        .o_out       (o_out.data)
    );
endmodule

// ===== sv/bpstego_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-plane stego port checker
// Observes the result channel of the top level and flags illegal behaviour.
// ----------------------------------------------------------------------------
module bpstego_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input bpstego_pkg::t_out i_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("Result changed or vanished while stalled.");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_data.byte_valid |-> i_data.extracted_byte == 8'd0)
        else $error("Extracted byte is non-zero without a completed byte.");

    a_oob_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.out_of_bounds |-> !i_data.byte_valid)
        else $error("Byte completed with the block origin out of bounds.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("Result valid directly after reset.");
endmodule

bind bitplane_block_stego_embed_extract bpstego_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_data  (o_out.data)
);
